>>> hw/rtl/prrf_pkg.sv
// Shared types and constants for the parking radar report framer.
// Used by the interfaces, the sensor lanes, the merge stage, the serializer and the top level.
package prrf_pkg;

  localparam int NUM_SENSORS     = 8;
  localparam int LANES_PER_FRAME = 4;
  localparam int CFG_IDX_W       = 4;
  localparam int POS_W           = 5;

  localparam logic [1:0] MODE_OFF = 2'd1;
  localparam logic [1:0] MODE_ON  = 2'd2;

  localparam logic [7:0]  MAX_RESET   = 8'd10;
  localparam logic [7:0]  DIST_LIMIT  = 8'd99;
  localparam logic [6:0]  DIST_TOP    = 7'd99;
  localparam logic [14:0] DIVISOR     = 15'd99;
  localparam logic [14:0] ROUND_UP    = 15'd98;
  localparam logic [23:0] RECIP       = 24'd661;
  localparam int          RECIP_SHIFT = 16;

  localparam logic [7:0] START_BYTE  = 8'h2E;
  localparam logic [7:0] TYPE_STATUS = 8'h24;
  localparam logic [7:0] TYPE_FRONT  = 8'h23;
  localparam logic [7:0] TYPE_REAR   = 8'h22;
  localparam logic [7:0] LEN_STATUS  = 8'h02;
  localparam logic [7:0] LEN_SENSOR  = 8'h04;
  localparam logic [7:0] PARK_ON_BIT = 8'h08;
  localparam logic [7:0] STATUS_D0   = 8'h00;
  localparam logic [7:0] CK_MASK     = 8'hFF;

  localparam logic [7:0] CK_STATUS_ON  = (TYPE_STATUS + LEN_STATUS + STATUS_D0 + PARK_ON_BIT)
                                         ^ CK_MASK;
  localparam logic [7:0] CK_STATUS_OFF = (TYPE_STATUS + LEN_STATUS + STATUS_D0) ^ CK_MASK;

  // Byte positions within the stream that one sample produces.
  localparam logic [POS_W-1:0] P_STATUS_START = 5'd0;
  localparam logic [POS_W-1:0] P_STATUS_TYPE  = 5'd1;
  localparam logic [POS_W-1:0] P_STATUS_LEN   = 5'd2;
  localparam logic [POS_W-1:0] P_STATUS_D0    = 5'd3;
  localparam logic [POS_W-1:0] P_STATUS_D1    = 5'd4;
  localparam logic [POS_W-1:0] P_STATUS_CK    = 5'd5;
  localparam logic [POS_W-1:0] P_FRONT_START  = 5'd6;
  localparam logic [POS_W-1:0] P_FRONT_TYPE   = 5'd7;
  localparam logic [POS_W-1:0] P_FRONT_LEN    = 5'd8;
  localparam logic [POS_W-1:0] P_FRONT_D0     = 5'd9;
  localparam logic [POS_W-1:0] P_FRONT_D1     = 5'd10;
  localparam logic [POS_W-1:0] P_FRONT_D2     = 5'd11;
  localparam logic [POS_W-1:0] P_FRONT_D3     = 5'd12;
  localparam logic [POS_W-1:0] P_FRONT_CK     = 5'd13;
  localparam logic [POS_W-1:0] P_REAR_START   = 5'd14;
  localparam logic [POS_W-1:0] P_REAR_TYPE    = 5'd15;
  localparam logic [POS_W-1:0] P_REAR_LEN     = 5'd16;
  localparam logic [POS_W-1:0] P_REAR_D0      = 5'd17;
  localparam logic [POS_W-1:0] P_REAR_D1      = 5'd18;
  localparam logic [POS_W-1:0] P_REAR_D2      = 5'd19;
  localparam logic [POS_W-1:0] P_REAR_D3      = 5'd20;
  localparam logic [POS_W-1:0] P_REAR_CK      = 5'd21;

  typedef struct packed {
    logic [1:0] radar_mode;
    logic [7:0] front_right_dist;
    logic [7:0] front_right_mid_dist;
    logic [7:0] front_left_mid_dist;
    logic [7:0] front_left_dist;
    logic [7:0] rear_left_dist;
    logic [7:0] rear_left_mid_dist;
    logic [7:0] rear_right_mid_dist;
    logic [7:0] rear_right_dist;
  } sample_t;

  typedef struct packed {
    logic [7:0] serial_byte;
    logic       frame_end;
    logic       run_last;
  } report_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } lane_ctl_t;

  typedef struct packed {
    logic                                park_on;
    logic [LANES_PER_FRAME-1:0][7:0]     front;
    logic [LANES_PER_FRAME-1:0][7:0]     rear;
    logic [7:0]                          front_ck;
    logic [7:0]                          rear_ck;
  } frame_t;

endpackage

>>> hw/rtl/prrf_if.sv
// Handshake channels of the parking radar report framer: samples in, bytes out, register writes.
// Depends on prrf_pkg for the payload types.
interface prrf_sample_if;
  import prrf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prrf_report_if;
  import prrf_pkg::*;
  logic    valid;
  logic    ready;
  report_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prrf_cfg_if;
  import prrf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/prrf_lane.sv
// One sensor lane: saturates a distance and scales it to a sensor byte in three stages.
// Depends on prrf_pkg; eight copies run side by side in the top level.
module prrf_lane
  import prrf_pkg::*;
(
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  logic [7:0] distance,
  input  logic [7:0] max_val,
  output logic [7:0] sensor_byte
);

  logic [6:0]  d_sat;
  logic [14:0] prod;
  logic [14:0] x1;
  logic [7:0]  m1;
  logic [23:0] est_full;
  logic [14:0] x2;
  logic [7:0]  est2;
  logic [7:0]  m2;
  logic [14:0] rem;
  logic [7:0]  quot;

  // The quotient by 99 comes from a reciprocal product that is low by at most one.
  assign d_sat    = (distance > DIST_LIMIT) ? DIST_TOP : distance[6:0];
  assign prod     = 15'(d_sat) * 15'(max_val);
  assign est_full = 24'(x1) * RECIP;
  assign rem      = x2 - 15'(est2) * DIVISOR;
  assign quot     = est2 + 8'(rem >= DIVISOR);

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      x1 <= prod + ROUND_UP;
      m1 <= max_val;
    end
    if (ctl.en2) begin
      x2   <= x1;
      est2 <= est_full[RECIP_SHIFT +: 8];
      m2   <= m1;
    end
    if (ctl.en3) begin
      sensor_byte <= m2 + 8'd1 - quot;
    end
  end

endmodule

>>> hw/rtl/prrf_merge.sv
// Merge stage: gathers the eight lane bytes into one frame set and forms the two checksums.
// Depends on prrf_pkg.
module prrf_merge
  import prrf_pkg::*;
(
  input  logic                          clk,
  input  logic                          en,
  input  logic                          park_on,
  input  logic [NUM_SENSORS-1:0][7:0]   lane_bytes,
  output frame_t                        frame
);

  frame_t frame_next;
  logic [7:0] front_sum;
  logic [7:0] rear_sum;

  always_comb begin
    front_sum = TYPE_FRONT + LEN_SENSOR;
    rear_sum  = TYPE_REAR + LEN_SENSOR;
    for (int i = 0; i < LANES_PER_FRAME; i++) begin
      front_sum = front_sum + lane_bytes[i];
      rear_sum  = rear_sum + lane_bytes[LANES_PER_FRAME + i];
    end
    frame_next.park_on  = park_on;
    for (int i = 0; i < LANES_PER_FRAME; i++) begin
      frame_next.front[i] = lane_bytes[i];
      frame_next.rear[i]  = lane_bytes[LANES_PER_FRAME + i];
    end
    frame_next.front_ck = front_sum ^ CK_MASK;
    frame_next.rear_ck  = rear_sum ^ CK_MASK;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame <= frame_next;
    end
  end

endmodule

>>> hw/rtl/prrf_serializer.sv
// Byte serializer: walks a sample's status frame, then front and rear frames if parking is on;
// one byte per cycle unless stalled. Depends on prrf_pkg and prrf_if; holds the output register.
module prrf_serializer
  import prrf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          frame_valid,
  input  frame_t        frame,
  output logic          take,
  prrf_report_if.source report
);

  frame_t           cur;
  logic             busy;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] last_pos;
  logic             at_last;
  logic             out_adv;
  logic [7:0]       byte_val;
  logic             is_ck;

  assign last_pos = cur.park_on ? P_REAR_CK : P_STATUS_CK;
  assign at_last  = (pos == last_pos);
  assign out_adv  = !report.valid || report.ready;
  assign take     = frame_valid && (!busy || (out_adv && at_last));
  assign is_ck    = (pos == P_STATUS_CK) || (pos == P_FRONT_CK) || (pos == P_REAR_CK);

  always_comb begin
    unique case (pos)
      P_STATUS_START, P_FRONT_START, P_REAR_START: byte_val = START_BYTE;
      P_STATUS_TYPE:  byte_val = TYPE_STATUS;
      P_STATUS_LEN:   byte_val = LEN_STATUS;
      P_STATUS_D0:    byte_val = STATUS_D0;
      P_STATUS_D1:    byte_val = cur.park_on ? PARK_ON_BIT : STATUS_D0;
      P_STATUS_CK:    byte_val = cur.park_on ? CK_STATUS_ON : CK_STATUS_OFF;
      P_FRONT_TYPE:   byte_val = TYPE_FRONT;
      P_REAR_TYPE:    byte_val = TYPE_REAR;
      P_FRONT_LEN, P_REAR_LEN: byte_val = LEN_SENSOR;
      P_FRONT_D0:     byte_val = cur.front[0];
      P_FRONT_D1:     byte_val = cur.front[1];
      P_FRONT_D2:     byte_val = cur.front[2];
      P_FRONT_D3:     byte_val = cur.front[3];
      P_FRONT_CK:     byte_val = cur.front_ck;
      P_REAR_D0:      byte_val = cur.rear[0];
      P_REAR_D1:      byte_val = cur.rear[1];
      P_REAR_D2:      byte_val = cur.rear[2];
      P_REAR_D3:      byte_val = cur.rear[3];
      P_REAR_CK:      byte_val = cur.rear_ck;
      default:        byte_val = START_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pos          <= P_STATUS_START;
      report.valid <= 1'b0;
    end else begin
      if (out_adv) begin
        report.valid <= busy;
      end
      if (take) begin
        busy <= 1'b1;
        pos  <= P_STATUS_START;
      end else if (busy && out_adv) begin
        pos <= pos + 5'd1;
        if (at_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= frame;
    end
    if (busy && out_adv) begin
      report.data <= '{serial_byte: byte_val, frame_end: is_ck, run_last: at_last};
    end
  end

  // The last byte of a sample always closes a frame.
  a_last_is_frame_end: assert property (@(posedge clk) disable iff (rst)
    report.valid && report.data.run_last |-> report.data.frame_end)
    else $error("run_last without frame_end");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pos <= last_pos)
    else $error("byte position beyond end of sample");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    take |=> busy && pos == P_STATUS_START)
    else $error("loaded frame set not started");

  a_take_needs_valid: assert property (@(posedge clk) disable iff (rst)
    take |-> frame_valid)
    else $error("frame set taken without valid");

endmodule

>>> hw/rtl/parking_radar_report_framer_top.sv
// Top level of the parking radar report framer: sample intake, park flag, eight sensor lanes,
// merge stage and byte serializer. Depends on prrf_pkg, prrf_if, prrf_lane, prrf_merge
// and prrf_serializer.
//
// A sample with radar mode on produces 22 bytes (status, front and rear frames), a sample that
// switches parking off produces the 6 status bytes, and other samples produce nothing. Bytes
// leave at one per cycle while the receiver does not stall, so the serializer sets the sustained
// rate. A sample passes three lane stages, the merge stage, the serializer's frame register and
// the output register before its first byte appears. The four stages in front of the serializer
// keep taking samples while it still sends earlier bytes. Register writes are taken every cycle.
module parking_radar_report_framer_top
  import prrf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  prrf_sample_if.sink   sample,
  prrf_report_if.source report,
  prrf_cfg_if.sink      cfg
);

  logic [NUM_SENSORS-1:0][7:0] sensor_max;
  logic [NUM_SENSORS-1:0][7:0] distance;
  logic [NUM_SENSORS-1:0][7:0] lane_bytes;
  logic       park_active;
  logic       mode_ok;
  logic       now_on;
  logic       v1, v2, v3, v4;
  logic       on1, on2, on3;
  logic       rdy1, rdy2, rdy3, rdy4;
  logic       take;
  lane_ctl_t  lane_ctl;
  frame_t     frame;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        sensor_max[i] <= MAX_RESET;
      end
    end else if (cfg.valid && (cfg.index < CFG_IDX_W'(NUM_SENSORS))) begin
      sensor_max[cfg.index[2:0]] <= cfg.data;
    end
  end

  assign distance[0] = sample.data.front_right_dist;
  assign distance[1] = sample.data.front_right_mid_dist;
  assign distance[2] = sample.data.front_left_mid_dist;
  assign distance[3] = sample.data.front_left_dist;
  assign distance[4] = sample.data.rear_left_dist;
  assign distance[5] = sample.data.rear_left_mid_dist;
  assign distance[6] = sample.data.rear_right_mid_dist;
  assign distance[7] = sample.data.rear_right_dist;

  assign mode_ok = (sample.data.radar_mode == MODE_OFF) || (sample.data.radar_mode == MODE_ON);
  assign now_on  = (sample.data.radar_mode == MODE_ON);

  assign rdy4 = !v4 || take;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign sample.ready = rdy1;
  assign lane_ctl = '{en1: rdy1, en2: rdy2, en3: rdy3};

  // Samples that produce no bytes go no further; those with a valid radar mode update the park flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      park_active <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (sample.valid && rdy1 && mode_ok) begin
        park_active <= now_on;
      end
      if (rdy1) begin
        v1 <= sample.valid && mode_ok && (park_active || now_on);
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      on1 <= now_on;
    end
    if (rdy2) begin
      on2 <= on1;
    end
    if (rdy3) begin
      on3 <= on2;
    end
  end

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    prrf_lane u_lane (
      .clk         (clk),
      .ctl         (lane_ctl),
      .distance    (distance[g]),
      .max_val     (sensor_max[g]),
      .sensor_byte (lane_bytes[g])
    );
  end

  prrf_merge u_merge (
    .clk        (clk),
    .en         (rdy4),
    .park_on    (on3),
    .lane_bytes (lane_bytes),
    .frame      (frame)
  );

  prrf_serializer u_serializer (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (v4),
    .frame       (frame),
    .take        (take),
    .report      (report)
  );

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the parking radar report framer: drives samples and register
// writes, predicts the framed byte stream and compares every byte. Depends on prrf_pkg,
// prrf_if and parking_radar_report_framer_top.
`timescale 1ns / 100ps

module tb_top;
  import prrf_pkg::*;

  localparam logic [1:0] MODE_UNDEF = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FRONT_RIGHT_MAX     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_RIGHT_MID_MAX = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_LEFT_MID_MAX  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_LEFT_MAX      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REAR_LEFT_MAX       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REAR_LEFT_MID_MAX   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REAR_RIGHT_MID_MAX  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REAR_RIGHT_MAX      = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST         = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST          = 4'd15;

  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int SETTLE_CYCLES   = 12;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MAX_RUN         = 22;

  logic clk = 1'b0;
  logic rst;

  always #6 clk = ~clk;

  prrf_sample_if sample_ch ();
  prrf_report_if report_ch ();
  prrf_cfg_if    cfg_ch ();

  parking_radar_report_framer_top dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch.sink),
    .report (report_ch.source),
    .cfg    (cfg_ch.sink)
  );

  sample_t    samples_to_send[$];
  report_t    report_bytes_due[$];
  logic [7:0] scale_max[NUM_SENSORS];
  logic       park_on;
  report_t    run_buf[MAX_RUN];
  int         run_len;

  int sender_idle_pct;
  int receiver_stall_pct;
  int error_count;
  int samples_taken;
  int samples_with_output;
  int bytes_checked;
  int cycle_count;

  function automatic logic [7:0] sensor_code(logic [7:0] distance, logic [7:0] m);
    int unsigned d;
    int unsigned up;
    d  = (distance > DIST_LIMIT) ? DIST_LIMIT : distance;
    up = (d * m + 98) / 99;
    return 8'(m + 1 - up);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic fe);
    run_buf[run_len] = '{serial_byte: b, frame_end: fe, run_last: 1'b0};
    run_len++;
  endfunction

  function automatic void add_frame(logic [7:0] ftype, logic [7:0] len,
                                    logic [3:0][7:0] body);
    logic [7:0] sum;
    sum = ftype + len;
    add_byte(START_BYTE, 1'b0);
    add_byte(ftype, 1'b0);
    add_byte(len, 1'b0);
    for (int k = 0; k < len; k++) begin
      add_byte(body[k], 1'b0);
      sum += body[k];
    end
    add_byte(sum ^ CK_MASK, 1'b1);
  endfunction

  function automatic void predict_report(sample_t s);
    logic            on_now;
    logic [3:0][7:0] fr;
    logic [3:0][7:0] rr;
    report_t         r;
    run_len = 0;
    if (s.radar_mode != MODE_OFF && s.radar_mode != MODE_ON) return;
    on_now = (s.radar_mode == MODE_ON);
    if (park_on != on_now || park_on) begin
      park_on = on_now;
      add_frame(TYPE_STATUS, LEN_STATUS,
                {8'h00, 8'h00, park_on ? PARK_ON_BIT : 8'h00, STATUS_D0});
    end
    if (park_on) begin
      fr[0] = sensor_code(s.front_right_dist,     scale_max[REG_FRONT_RIGHT_MAX[2:0]]);
      fr[1] = sensor_code(s.front_right_mid_dist, scale_max[REG_FRONT_RIGHT_MID_MAX[2:0]]);
      fr[2] = sensor_code(s.front_left_mid_dist,  scale_max[REG_FRONT_LEFT_MID_MAX[2:0]]);
      fr[3] = sensor_code(s.front_left_dist,      scale_max[REG_FRONT_LEFT_MAX[2:0]]);
      rr[0] = sensor_code(s.rear_left_dist,       scale_max[REG_REAR_LEFT_MAX[2:0]]);
      rr[1] = sensor_code(s.rear_left_mid_dist,   scale_max[REG_REAR_LEFT_MID_MAX[2:0]]);
      rr[2] = sensor_code(s.rear_right_mid_dist,  scale_max[REG_REAR_RIGHT_MID_MAX[2:0]]);
      rr[3] = sensor_code(s.rear_right_dist,      scale_max[REG_REAR_RIGHT_MAX[2:0]]);
      add_frame(TYPE_FRONT, LEN_SENSOR, fr);
      add_frame(TYPE_REAR, LEN_SENSOR, rr);
    end
    if (run_len > 0) samples_with_output++;
    for (int k = 0; k < run_len; k++) begin
      r = run_buf[k];
      r.run_last = (k == run_len - 1);
      report_bytes_due.push_back(r);
    end
  endfunction

  function automatic sample_t sample_of(logic [1:0] mode, logic [7:0][7:0] d);
    sample_t s;
    s.radar_mode           = mode;
    s.front_right_dist     = d[0];
    s.front_right_mid_dist = d[1];
    s.front_left_mid_dist  = d[2];
    s.front_left_dist      = d[3];
    s.rear_left_dist       = d[4];
    s.rear_left_mid_dist   = d[5];
    s.rear_right_mid_dist  = d[6];
    s.rear_right_dist      = d[7];
    return s;
  endfunction

  function automatic logic [7:0] rand_dist();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 8'($urandom_range(0, 99));
      6:                return $urandom_range(0, 1) ? 8'd99 : 8'd0;
      7:                return 8'($urandom_range(98, 101));
      default:          return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < NUM_SENSORS) scale_max[idx[2:0]] = val;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (samples_to_send.size() != 0 || sample_ch.valid || report_bytes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        predict_report(sample_ch.data);
        samples_taken++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          sample_ch.data  <= samples_to_send.pop_front();
          sample_ch.valid <= 1'b1;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    report_t want;
    report_t got;
    if (rst) begin
      report_ch.ready <= 1'b0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        got = report_ch.data;
        bytes_checked++;
        if (report_bytes_due.size() == 0) begin
          $error("unexpected byte %02h with no prediction pending", got.serial_byte);
          error_count++;
        end else begin
          want = report_bytes_due.pop_front();
          if (got.serial_byte !== want.serial_byte) begin
            $error("serial_byte: expected %02h, got %02h", want.serial_byte, got.serial_byte);
            error_count++;
          end
          if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
            error_count++;
          end
          if (got.run_last !== want.run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
            error_count++;
          end
        end
      end
      report_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still due", cycle_count,
               report_bytes_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int              produced;
    int              roll;
    logic            plan_on;
    logic [1:0]      mode;
    logic [7:0][7:0] dists;

    rst                 = 1'b1;
    sample_ch.valid     = 1'b0;
    sample_ch.data      = '0;
    report_ch.ready     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    sender_idle_pct     = 0;
    receiver_stall_pct  = 0;
    error_count         = 0;
    samples_taken       = 0;
    samples_with_output = 0;
    bytes_checked       = 0;
    cycle_count         = 0;
    park_on             = 1'b0;
    run_len             = 0;
    plan_on             = 1'b0;
    for (int k = 0; k < NUM_SENSORS; k++) scale_max[k] = MAX_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        for (int r = REG_FRONT_RIGHT_MAX; r <= REG_REAR_RIGHT_MAX; r++) begin
          case (phase)
            1:       write_reg(CFG_IDX_W'(r), 8'd0);
            2:       write_reg(CFG_IDX_W'(r), 8'd255);
            3:       write_reg(CFG_IDX_W'(r), 8'd254);
            default: write_reg(CFG_IDX_W'(r), 8'($urandom_range(0, 255)));
          endcase
        end
        if (phase == NUM_PHASES - 1) begin
          write_reg(REG_SPARE_FIRST, 8'($urandom_range(0, 255)));
          write_reg(REG_SPARE_LAST, 8'($urandom_range(0, 255)));
        end
      end

      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase

      if (phase == 0) begin
        samples_to_send.push_back(sample_of(MODE_UNDEF, {8{8'hFF}}));
        samples_to_send.push_back(sample_of(MODE_SPARE, {8{8'hFF}}));
        samples_to_send.push_back(sample_of(MODE_OFF, {8{8'd0}}));
        samples_to_send.push_back(sample_of(MODE_ON, {8{8'd0}}));
        samples_to_send.push_back(sample_of(MODE_ON, {8{8'd99}}));
        samples_to_send.push_back(sample_of(MODE_ON, {8{8'd100}}));
        samples_to_send.push_back(sample_of(MODE_ON, {8{8'd255}}));
        samples_to_send.push_back(sample_of(MODE_ON,
          {8'd1, 8'd98, 8'd50, 8'd33, 8'd66, 8'd9, 8'd100, 8'd97}));
        samples_to_send.push_back(sample_of(MODE_ON, {8{8'hAA}}));
        samples_to_send.push_back(sample_of(MODE_ON, {8{8'h55}}));
        samples_to_send.push_back(sample_of(MODE_UNDEF, {8{8'h00}}));
        samples_to_send.push_back(sample_of(MODE_SPARE, {8{8'h00}}));
        samples_to_send.push_back(sample_of(MODE_ON, {8'd10, 8'd20, 8'd30, 8'd40,
                                                      8'd60, 8'd70, 8'd80, 8'd90}));
        samples_to_send.push_back(sample_of(MODE_OFF, {8{8'd50}}));
        samples_to_send.push_back(sample_of(MODE_OFF, {8{8'd50}}));
        samples_to_send.push_back(sample_of(MODE_ON, {8{8'd11}}));
        samples_to_send.push_back(sample_of(MODE_OFF, {8{8'hFF}}));
      end

      produced = 0;
      while (produced < ITEMS_PER_PHASE) begin
        for (int k = 0; k < NUM_SENSORS; k++) dists[k] = rand_dist();
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          mode = roll[0] ? MODE_SPARE : MODE_UNDEF;
        end else begin
          if ($urandom_range(0, 99) < 15) plan_on = !plan_on;
          mode = plan_on ? MODE_ON : MODE_OFF;
        end
        samples_to_send.push_back(sample_of(mode, dists));
        produced++;
      end
    end

    wait_idle();
    $display("Checked %0d bytes from %0d samples, %0d of which produced frames,",
             bytes_checked, samples_taken, samples_with_output);
    $display("across %0d register settings and four handshake pacing modes.", NUM_PHASES);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
